// ----- rtl/core/fcsm_pkg.sv -----
`timescale 1ns / 1ps

package fcsm_pkg;

  localparam int unsigned NADDR_W     = 22;
  localparam int unsigned NIB_W       = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WARN_W      = 2;
  localparam int unsigned CNT_FIELD_W = 5;
  localparam int unsigned S_TDATA_W   = 32;
  localparam int unsigned M_TDATA_W   = 8;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  localparam logic [BYTE_W-1:0] OP_READ_ARRAY   = 8'hFF;
  localparam logic [BYTE_W-1:0] OP_CLEAR_STATUS = 8'h50;
  localparam logic [BYTE_W-1:0] OP_WRITE_BUFFER = 8'hE8;
  localparam logic [BYTE_W-1:0] OP_READ_STATUS  = 8'h70;
  localparam logic [BYTE_W-1:0] OP_ERASE        = 8'h20;
  localparam logic [BYTE_W-1:0] OP_CONFIRM      = 8'hD0;

  localparam logic [BYTE_W-1:0] STATUS_READY = 8'h80;
  localparam logic [BYTE_W-1:0] ERASED_BYTE  = 8'hFF;

  localparam logic [WARN_W-1:0] WARN_NONE    = 2'd0;
  localparam logic [WARN_W-1:0] WARN_BAD_CMD = 2'd1;
  localparam logic [WARN_W-1:0] WARN_WINDOW  = 2'd2;
  localparam logic [WARN_W-1:0] WARN_UNUSED  = 2'd3;

  typedef enum logic [6:0] {
    CMD_ARRAY      = 7'b0000001,
    CMD_STATUS     = 7'b0000010,
    CMD_XSTATUS    = 7'b0000100,
    CMD_DATA_FIRST = 7'b0001000,
    CMD_DATA_MORE  = 7'b0010000,
    CMD_CONFIRM    = 7'b0100000,
    CMD_ERASE      = 7'b1000000
  } cmd_state_e;

  typedef enum logic [5:0] {
    SEQ_CLEAR  = 6'b000001,
    SEQ_IDLE   = 6'b000010,
    SEQ_EXEC   = 6'b000100,
    SEQ_COMMIT = 6'b001000,
    SEQ_DRAIN  = 6'b010000,
    SEQ_ERASE  = 6'b100000
  } seq_state_e;

endpackage

// ----- rtl/core/fcsm_flash_mem.sv -----
`timescale 1ns / 1ps

module fcsm_flash_mem #(
  parameter int unsigned ADDR_W = 21
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [ADDR_W-1:0]           wr_addr_i,
  input  logic [fcsm_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [ADDR_W-1:0]           rd_addr_i,
  output logic [fcsm_pkg::BYTE_W-1:0] rd_data_o
);

  logic [fcsm_pkg::BYTE_W-1:0] mem [2**ADDR_W];
  logic [fcsm_pkg::BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/fcsm_buf_mem.sv -----
`timescale 1ns / 1ps

module fcsm_buf_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX_W = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [IDX_W-1:0]            wr_idx_i,
  input  logic [fcsm_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [IDX_W-1:0]            rd_idx_i,
  output logic [fcsm_pkg::BYTE_W-1:0] rd_data_o
);

  logic [fcsm_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [fcsm_pkg::BYTE_W-1:0] rd_data_q;
  logic [DEPTH-1:0]            valid_q;
  logic                        rd_valid_q;

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- rtl/core/flash_command_state_machine.sv -----
`timescale 1ns / 1ps

// Byte-wide flash array with its command state machine, driven by nibble read and write
// transactions on the input stream, one result transaction per input. A nibble transaction
// is first accepted, which starts the array read; the command step then executes on the
// registered read data and loads the output register, waiting while that register still
// holds an unaccepted result; a finished result may wait in that register while the next
// transaction is accepted. A confirmed buffer write holds off input while the buffer memory
// is copied into the array one byte per cycle, and a confirmed block erase holds it off
// while the block is erased, one array write per cycle. After reset the array is filled with
// the erased value, one byte per cycle, before the first transaction is accepted.
module flash_command_state_machine #(
  parameter int unsigned BYTE_ADDR_BITS = 21,
  parameter int unsigned BLOCK_BYTES    = 65536,
  parameter int unsigned BUFFER_BYTES   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: nibble_address[21:0], write_nibble[25:22], zero fill.
  input  logic [fcsm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: op.
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: read_nibble[3:0], warning[5:4], zero fill.
  output logic [fcsm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned ADDR_W = BYTE_ADDR_BITS;
  localparam int unsigned BLK_W  = $clog2(BLOCK_BYTES);
  localparam int unsigned BUF_W  = $clog2(BUFFER_BYTES);
  localparam int unsigned HI_W   = ADDR_W - BLK_W;

  fcsm_pkg::seq_state_e seq_q, seq_d;
  fcsm_pkg::cmd_state_e cmd_q, cmd_d;

  logic                            op_q;
  logic [fcsm_pkg::NADDR_W-1:0]    naddr_q;
  logic [fcsm_pkg::NIB_W-1:0]      nib_q;
  logic [fcsm_pkg::BYTE_W-1:0]     rd_hold_q, rd_hold_d;
  logic [fcsm_pkg::NIB_W-1:0]      wnib_hold_q, wnib_hold_d;
  logic [BUF_W-1:0]                last_idx_q, last_idx_d;
  logic [BUF_W-1:0]                cnt_q, cnt_d;
  logic [ADDR_W-1:0]               base_q, base_d;
  logic                            out_valid_q, out_valid_d;
  logic [fcsm_pkg::M_TDATA_W-1:0]  out_data_q, out_data_d;
  logic [ADDR_W-1:0]               clr_q, clr_d;
  logic [HI_W-1:0]                 ers_base_q, ers_base_d;
  logic [BLK_W-1:0]                ers_q, ers_d;
  logic [BUF_W-1:0]                cidx_q, cidx_d;
  logic                            pend_q, pend_d;
  logic [BUF_W-1:0]                pend_idx_q, pend_idx_d;

  logic                            accept;
  logic                            out_free;
  logic [ADDR_W-1:0]               addr;
  logic [ADDR_W-1:0]               diff;
  logic [fcsm_pkg::BYTE_W-1:0]     wbyte;
  logic [fcsm_pkg::BYTE_W-1:0]     rbyte;
  logic [fcsm_pkg::CNT_FIELD_W-1:0] cnt_field;
  logic [fcsm_pkg::CNT_FIELD_W-1:0] cnt_sat;
  logic [fcsm_pkg::WARN_W-1:0]     warn;
  logic [fcsm_pkg::NIB_W-1:0]      rd_nib;

  logic                            fl_wr_en;
  logic [ADDR_W-1:0]               fl_wr_addr;
  logic [fcsm_pkg::BYTE_W-1:0]     fl_wr_data;
  logic [ADDR_W-1:0]               fl_rd_addr;
  logic [fcsm_pkg::BYTE_W-1:0]     fl_rd_data;

  logic                            bf_wr_en;
  logic [BUF_W-1:0]                bf_wr_idx;
  logic                            bf_rd_en;
  logic [fcsm_pkg::BYTE_W-1:0]     bf_rd_data;

  assign s_axis_tready = (seq_q == fcsm_pkg::SEQ_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fl_rd_addr    = ADDR_W'(s_axis_tdata[fcsm_pkg::NADDR_W-1:0] >> 1);

  assign addr      = ADDR_W'(naddr_q >> 1);
  assign diff      = addr - base_q;
  assign wbyte     = {nib_q, wnib_hold_q};
  assign cnt_field = wbyte[fcsm_pkg::CNT_FIELD_W-1:0];
  assign cnt_sat   = (cnt_field > fcsm_pkg::CNT_FIELD_W'(BUFFER_BYTES - 1))
                   ? fcsm_pkg::CNT_FIELD_W'(BUFFER_BYTES - 1) : cnt_field;

  fcsm_flash_mem #(
    .ADDR_W(ADDR_W)
  ) u_flash (
    .clk_i    (clk_i),
    .wr_en_i  (fl_wr_en),
    .wr_addr_i(fl_wr_addr),
    .wr_data_i(fl_wr_data),
    .rd_en_i  (accept),
    .rd_addr_i(fl_rd_addr),
    .rd_data_o(fl_rd_data)
  );

  fcsm_buf_mem #(
    .DEPTH(BUFFER_BYTES),
    .IDX_W(BUF_W)
  ) u_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (bf_wr_en),
    .wr_idx_i (bf_wr_idx),
    .wr_data_i(wbyte),
    .rd_en_i  (bf_rd_en),
    .rd_idx_i (cidx_q),
    .rd_data_o(bf_rd_data)
  );

  always_comb begin
    seq_d       = seq_q;
    cmd_d       = cmd_q;
    rd_hold_d   = rd_hold_q;
    wnib_hold_d = wnib_hold_q;
    last_idx_d  = last_idx_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    clr_d       = clr_q;
    ers_base_d  = ers_base_q;
    ers_d       = ers_q;
    cidx_d      = cidx_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    warn        = fcsm_pkg::WARN_NONE;
    rd_nib      = '0;
    rbyte       = '0;
    fl_wr_en    = 1'b0;
    fl_wr_addr  = base_q + ADDR_W'(pend_idx_q);
    fl_wr_data  = bf_rd_data;
    bf_wr_en    = 1'b0;
    bf_wr_idx   = '0;
    bf_rd_en    = 1'b0;

    if (pend_q) begin
      fl_wr_en = 1'b1;
    end

    case (seq_q)
      fcsm_pkg::SEQ_CLEAR: begin
        fl_wr_en   = 1'b1;
        fl_wr_addr = clr_q;
        fl_wr_data = fcsm_pkg::ERASED_BYTE;
        clr_d      = clr_q + 1'b1;
        if (&clr_q) begin
          seq_d = fcsm_pkg::SEQ_IDLE;
        end
      end
      fcsm_pkg::SEQ_IDLE: begin
        if (accept) begin
          seq_d = fcsm_pkg::SEQ_EXEC;
        end
      end
      fcsm_pkg::SEQ_EXEC: begin
        if (out_free) begin
          seq_d = fcsm_pkg::SEQ_IDLE;
          if (op_q == fcsm_pkg::ACC_READ) begin
            if (naddr_q[0]) begin
              rd_nib = rd_hold_q[7:4];
            end else begin
              case (cmd_q)
                fcsm_pkg::CMD_STATUS, fcsm_pkg::CMD_XSTATUS: begin
                  rbyte = fcsm_pkg::STATUS_READY;
                end
                fcsm_pkg::CMD_DATA_FIRST, fcsm_pkg::CMD_DATA_MORE,
                fcsm_pkg::CMD_CONFIRM, fcsm_pkg::CMD_ERASE: begin
                  warn  = fcsm_pkg::WARN_BAD_CMD;
                  cmd_d = fcsm_pkg::CMD_ARRAY;
                end
                default: begin
                  rbyte = fl_rd_data;
                end
              endcase
              rd_hold_d = rbyte;
              rd_nib    = rbyte[3:0];
            end
          end else if (!naddr_q[0]) begin
            wnib_hold_d = nib_q;
          end else begin
            case (cmd_q)
              fcsm_pkg::CMD_XSTATUS: begin
                last_idx_d = BUF_W'(cnt_sat);
                cnt_d      = BUF_W'(cnt_sat);
                cmd_d      = fcsm_pkg::CMD_DATA_FIRST;
              end
              fcsm_pkg::CMD_DATA_FIRST, fcsm_pkg::CMD_DATA_MORE: begin
                if (cmd_q == fcsm_pkg::CMD_DATA_FIRST) begin
                  base_d    = addr;
                  bf_wr_en  = 1'b1;
                  bf_wr_idx = '0;
                  cmd_d     = fcsm_pkg::CMD_DATA_MORE;
                end else if (addr >= base_q && diff < ADDR_W'(BUFFER_BYTES)) begin
                  bf_wr_en  = 1'b1;
                  bf_wr_idx = diff[BUF_W-1:0];
                end else begin
                  warn = fcsm_pkg::WARN_WINDOW;
                end
                if (cnt_q == '0) begin
                  cmd_d = fcsm_pkg::CMD_CONFIRM;
                end else begin
                  cnt_d = cnt_q - 1'b1;
                end
              end
              fcsm_pkg::CMD_CONFIRM: begin
                if (wbyte == fcsm_pkg::OP_CONFIRM) begin
                  seq_d  = fcsm_pkg::SEQ_COMMIT;
                  cidx_d = '0;
                end
                cmd_d = fcsm_pkg::CMD_ARRAY;
              end
              fcsm_pkg::CMD_ERASE: begin
                if (wbyte == fcsm_pkg::OP_CONFIRM) begin
                  seq_d      = fcsm_pkg::SEQ_ERASE;
                  ers_base_d = addr[ADDR_W-1:BLK_W];
                  ers_d      = '0;
                end
                cmd_d = fcsm_pkg::CMD_STATUS;
              end
              default: begin
                case (wbyte)
                  fcsm_pkg::OP_READ_ARRAY:   cmd_d = fcsm_pkg::CMD_ARRAY;
                  fcsm_pkg::OP_CLEAR_STATUS: cmd_d = cmd_q;
                  fcsm_pkg::OP_WRITE_BUFFER: cmd_d = fcsm_pkg::CMD_XSTATUS;
                  fcsm_pkg::OP_READ_STATUS:  cmd_d = fcsm_pkg::CMD_STATUS;
                  fcsm_pkg::OP_ERASE:        cmd_d = fcsm_pkg::CMD_ERASE;
                  default:                   warn  = fcsm_pkg::WARN_BAD_CMD;
                endcase
              end
            endcase
          end
          out_valid_d = 1'b1;
          out_data_d  = fcsm_pkg::M_TDATA_W'({warn, rd_nib});
        end
      end
      fcsm_pkg::SEQ_COMMIT: begin
        bf_rd_en   = 1'b1;
        pend_d     = 1'b1;
        pend_idx_d = cidx_q;
        if (cidx_q == last_idx_q) begin
          seq_d = fcsm_pkg::SEQ_DRAIN;
        end else begin
          cidx_d = cidx_q + 1'b1;
        end
      end
      fcsm_pkg::SEQ_DRAIN: begin
        seq_d = fcsm_pkg::SEQ_IDLE;
      end
      fcsm_pkg::SEQ_ERASE: begin
        fl_wr_en   = 1'b1;
        fl_wr_addr = {ers_base_q, ers_q};
        fl_wr_data = fcsm_pkg::ERASED_BYTE;
        ers_d      = ers_q + 1'b1;
        if (&ers_q) begin
          seq_d = fcsm_pkg::SEQ_IDLE;
        end
      end
      default: begin
        seq_d = fcsm_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= fcsm_pkg::SEQ_CLEAR;
      cmd_q       <= fcsm_pkg::CMD_ARRAY;
      rd_hold_q   <= '0;
      wnib_hold_q <= '0;
      last_idx_q  <= '0;
      cnt_q       <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      pend_q      <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      cmd_q       <= cmd_d;
      rd_hold_q   <= rd_hold_d;
      wnib_hold_q <= wnib_hold_d;
      last_idx_q  <= last_idx_d;
      cnt_q       <= cnt_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= s_axis_tuser;
      naddr_q <= s_axis_tdata[fcsm_pkg::NADDR_W-1:0];
      nib_q   <= s_axis_tdata[fcsm_pkg::NADDR_W +: fcsm_pkg::NIB_W];
    end
    out_data_q <= out_data_d;
    ers_base_q <= ers_base_d;
    ers_q      <= ers_d;
    cidx_q     <= cidx_d;
    pend_idx_q <= pend_idx_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/core/fcsm_checker.sv -----
`timescale 1ns / 1ps

module fcsm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [fcsm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fcsm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic       s_acc;
  logic       m_acc;
  logic [1:0] open_q;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (s_acc && !m_acc) begin
      open_q <= open_q + 1'b1;
    end else if (m_acc && !s_acc) begin
      open_q <= open_q - 1'b1;
    end
  end

  a_out_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("transaction accepted while another is executing");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> open_q != 2'd0 && open_q != 2'd3)
    else $error("result without a matching input transaction");

  a_warn_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[5:4] != fcsm_pkg::WARN_UNUSED)
    else $error("unused warning code");

  a_window_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5:4] == fcsm_pkg::WARN_WINDOW |-> m_axis_tdata[3:0] == '0)
    else $error("buffer window warning with read data");

endmodule

bind flash_command_state_machine fcsm_checker u_fcsm_checker (.*);
